// ===== design/tops_pkg.sv =====
// ----------------------------------------------------------------------------
// tops_pkg
// Shared types and constants for the thermal and overcurrent protection unit.
// ----------------------------------------------------------------------------
package tops_pkg;

    localparam int unsigned ADDR_W = 4;

    // Register indexes: paddr[3:2]
    typedef enum logic [1:0] {
        REG_CURRENT_LIMIT    = 2'd0,
        REG_TRIP_PERSISTENCE = 2'd1,
        REG_HEATSINK_THR     = 2'd2,
        REG_TRANSFORMER_THR  = 2'd3
    } t_reg_idx;

    localparam logic [7:0]  CURRENT_LIMIT_RST    = 8'hFF;
    localparam logic [7:0]  TRIP_PERSISTENCE_RST = 8'd3;
    localparam logic [31:0] THRESHOLDS_RST       = 32'hFFFF_FFFF;
    localparam logic [7:0]  COUNT_MAX            = 8'hFF;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_FAN      = 2'd1,
        MODE_SHUTDOWN = 2'd2
    } t_mode;

    // Threshold register layout, high byte first
    typedef struct packed {
        logic [7:0] shut_release;
        logic [7:0] fan_release;
        logic [7:0] shut_on;
        logic [7:0] fan_on;
    } t_thresholds;

    typedef struct packed {
        logic [7:0] current_sample;
        logic [7:0] heatsink_sample;
        logic [7:0] transformer_sample;
    } t_in_item;

    typedef struct packed {
        logic       fan_on;
        logic       overcurrent_trip;
        logic [1:0] heatsink_mode;
        logic       heatsink_alarm;
        logic [1:0] transformer_mode;
        logic       transformer_alarm;
        logic       shutdown_request;
    } t_out_item;

    // One sensor's status after the step
    typedef struct packed {
        logic  fan;
        t_mode mode;
        logic  alarm;
    } t_sensor_out;

endpackage

// ===== design/tops_sensor.sv =====
// ----------------------------------------------------------------------------
// tops_sensor
// Three-state hysteresis machine for one temperature sensor, sticky alarm.
// ----------------------------------------------------------------------------
module tops_sensor
    import tops_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [7:0]  i_sample,
    input  t_thresholds i_thr,
    output t_sensor_out o_next
);

    t_mode r_state;
    t_mode n_state;
    logic  r_flag;
    logic  n_flag;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MODE_NORMAL: begin
                if (i_sample > i_thr.shut_on) begin
                    n_state = MODE_SHUTDOWN;
                end else if (i_sample > i_thr.fan_on) begin
                    n_state = MODE_FAN;
                end else begin
                    n_state = MODE_NORMAL;
                end
            end
            MODE_FAN: begin
                if (i_sample > i_thr.fan_release) begin
                    n_state = MODE_FAN;
                end else begin
                    n_state = MODE_NORMAL;
                end
            end
            default: begin
                // shutdown, and the unused code treated as shutdown
                if (i_sample > i_thr.shut_release) begin
                    n_state = MODE_SHUTDOWN;
                end else if (i_sample > i_thr.fan_release) begin
                    n_state = MODE_FAN;
                end else begin
                    n_state = MODE_NORMAL;
                end
            end
        endcase
    end

    // outputs: alarm follows the destination, fan is any non-normal state
    always_comb begin
        n_flag = r_flag;
        unique case (n_state)
            MODE_SHUTDOWN: n_flag = 1'b1;
            MODE_NORMAL:   n_flag = (r_state == MODE_FAN) ? r_flag : 1'b0;
            default:       n_flag = r_flag;
        endcase
        o_next.fan   = (n_state != MODE_NORMAL);
        o_next.mode  = n_state;
        o_next.alarm = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MODE_NORMAL;
            r_flag  <= 1'b0;
        end else if (i_adv) begin
            r_state <= n_state;
            r_flag  <= n_flag;
        end
    end

endmodule

// ===== design/tops_ocp.sv =====
// ----------------------------------------------------------------------------
// tops_ocp
// Overcurrent persistence counter, saturating, with trip decision.
// ----------------------------------------------------------------------------
module tops_ocp
    import tops_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_current,
    input  logic [7:0] i_limit,
    input  logic [7:0] i_persist,
    output logic       o_trip
);

    logic [7:0] r_count;
    logic [7:0] n_count;
    logic       over;

    always_comb begin
        over = (i_current >= i_limit);
        if (!over) begin
            n_count = '0;
        end else if (r_count == COUNT_MAX) begin
            n_count = r_count;
        end else begin
            n_count = r_count + 8'd1;
        end
        o_trip = over && (n_count >= i_persist);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_adv) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== design/thermal_overcurrent_protection_unit.sv =====
// ----------------------------------------------------------------------------
// thermal_overcurrent_protection_unit
// Overcurrent persistence trip plus two hysteresis thermal machines with
// sticky alarms, combined fan and shutdown outputs.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+------------------------------
//  input    | i_in_valid  / o_in_ready        | i_in_data  (t_in_item)
//  output   | o_out_valid / i_out_ready       | o_out_data (t_out_item)
//  config   | psel, penable, pwrite / pready  | paddr, pwdata, prdata
//
//  One sample set per cycle sustained while i_out_ready stays high. A transfer
//  lands in the input register, the decision logic works on it and the result
//  register loads from it, raising o_out_valid.
//  Stalls: the input register advances whenever the result register is empty
//  or being drained, so input and output stall independently by one stage.
//  Reset (synchronous, active low) clears valids, counter and machines, and
//  loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module thermal_overcurrent_protection_unit
    import tops_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------- configuration registers ----------------
    logic [7:0]  r_current_limit;
    logic [7:0]  r_trip_persistence;
    logic [31:0] r_heatsink_thr;
    logic [31:0] r_transformer_thr;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);   // byte lanes ignored

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_limit    <= CURRENT_LIMIT_RST;
            r_trip_persistence <= TRIP_PERSISTENCE_RST;
            r_heatsink_thr     <= THRESHOLDS_RST;
            r_transformer_thr  <= THRESHOLDS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CURRENT_LIMIT:    r_current_limit    <= pwdata[7:0];
                REG_TRIP_PERSISTENCE: r_trip_persistence <= pwdata[7:0];
                REG_HEATSINK_THR:     r_heatsink_thr     <= pwdata;
                REG_TRANSFORMER_THR:  r_transformer_thr  <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_CURRENT_LIMIT:    prdata = {24'd0, r_current_limit};
            REG_TRIP_PERSISTENCE: prdata = {24'd0, r_trip_persistence};
            REG_HEATSINK_THR:     prdata = r_heatsink_thr;
            REG_TRANSFORMER_THR:  prdata = r_transformer_thr;
        endcase
    end

    // ---------------- input register ----------------
    logic      r_in_valid;
    t_in_item  r_in;
    logic      adv;         // item moves from input register to result register
    logic      r_out_valid;
    t_out_item r_out;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // ---------------- decision logic ----------------
    logic        trip;
    t_sensor_out hs_next;
    t_sensor_out tr_next;
    t_out_item   n_out;

    tops_ocp u_ocp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_current (r_in.current_sample),
        .i_limit   (r_current_limit),
        .i_persist (r_trip_persistence),
        .o_trip    (trip)
    );

    tops_sensor u_heatsink (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_sample (r_in.heatsink_sample),
        .i_thr    (t_thresholds'(r_heatsink_thr)),
        .o_next   (hs_next)
    );

    tops_sensor u_transformer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_sample (r_in.transformer_sample),
        .i_thr    (t_thresholds'(r_transformer_thr)),
        .o_next   (tr_next)
    );

    always_comb begin
        n_out.fan_on            = hs_next.fan || tr_next.fan;
        n_out.overcurrent_trip  = trip;
        n_out.heatsink_mode     = hs_next.mode;
        n_out.heatsink_alarm    = hs_next.alarm;
        n_out.transformer_mode  = tr_next.mode;
        n_out.transformer_alarm = tr_next.alarm;
        n_out.shutdown_request  = trip || (hs_next.mode == MODE_SHUTDOWN)
                                       || (tr_next.mode == MODE_SHUTDOWN);
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // an empty input register always takes a transfer
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input register empty but not ready");

    // unused mode code never reaches the output
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.heatsink_mode != 2'd3) && (r_out.transformer_mode != 2'd3))
        else $error("illegal sensor mode in result");

    // shutdown always carries the sticky alarm
    a_shutdown_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ((r_out.heatsink_mode == MODE_SHUTDOWN && !r_out.heatsink_alarm)
                     || (r_out.transformer_mode == MODE_SHUTDOWN
                         && !r_out.transformer_alarm)) |-> 1'b0)
        else $error("shutdown mode without alarm");

    // any non-normal sensor drives the fan
    a_fan_demand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ((r_out.heatsink_mode != MODE_NORMAL)
                     || (r_out.transformer_mode != MODE_NORMAL)) |-> r_out.fan_on)
        else $error("sensor out of normal but fan off");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thermal and overcurrent protection unit. Sample
// sets stream in over valid/ready in random bursts, results are drained by a
// stalling receiver and compared field by field with an in-bench predictor.
// Settings are changed between phases through the APB port and read back.
// ----------------------------------------------------------------------------
module tb;
    import tops_pkg::*;

    localparam int PIPE_LATENCY   = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 60;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    thermal_overcurrent_protection_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_in_item  sample_q[$];          // sample sets waiting to be driven
    t_out_item expected_status_q[$]; // predicted results, oldest first

    int pushed_total    = 0;
    int accepted_total  = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int settings_used   = 0;
    int mismatch_count  = 0;

    // Sender burst shaping
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver stall shaping; the stimulus bumps hold_off_req to ask for a
    // long stretch of ready low, counted in the receiver's own process
    int hold_off_req  = 0;
    int hold_off_seen = 0;
    int hold_left     = 0;
    int stall_style   = 0;
    int style_left    = 0;

    // Current-run shaping for random stimulus
    int oc_run_left = 0;

    // ------------------------------------------------------------------------
    // Predictor: settings shadow and protection state
    // ------------------------------------------------------------------------
    logic [7:0]  cur_limit_cfg = CURRENT_LIMIT_RST;
    logic [7:0]  persist_cfg   = TRIP_PERSISTENCE_RST;
    t_thresholds hs_thr_cfg    = THRESHOLDS_RST;
    t_thresholds tr_thr_cfg    = THRESHOLDS_RST;

    logic [7:0] oc_count = '0;
    t_mode      hs_mode  = MODE_NORMAL;
    t_mode      tr_mode  = MODE_NORMAL;
    logic       hs_alarm = 1'b0;
    logic       tr_alarm = 1'b0;

    // One hysteresis machine step; returns that sensor's fan demand.
    // Strict greater-than compares against each threshold byte.
    function automatic logic step_thermal_machine(input logic [7:0] temp,
                                                  input t_thresholds thr,
                                                  inout t_mode mode,
                                                  inout logic alarm);
        logic fan;
        fan = 1'b1;
        case (mode)
            MODE_NORMAL: begin
                if (temp > thr.shut_on) begin
                    mode  = MODE_SHUTDOWN;
                    alarm = 1'b1;
                end else if (temp > thr.fan_on) begin
                    mode = MODE_FAN;
                end else begin
                    alarm = 1'b0;
                    fan   = 1'b0;
                end
            end
            MODE_FAN: begin
                // dropping back to normal keeps the alarm as it was
                if (temp <= thr.fan_release) begin
                    mode = MODE_NORMAL;
                    fan  = 1'b0;
                end
            end
            default: begin
                // shutdown, and the never-entered code 3
                if (temp > thr.shut_release) begin
                    mode  = MODE_SHUTDOWN;
                    alarm = 1'b1;
                end else if (temp > thr.fan_release) begin
                    mode = MODE_FAN;
                end else begin
                    mode  = MODE_NORMAL;
                    alarm = 1'b0;
                    fan   = 1'b0;
                end
            end
        endcase
        return fan;
    endfunction

    function automatic t_out_item predict_protection_status(input t_in_item s);
        t_out_item r;
        logic      trip;
        logic      fan_hs;
        logic      fan_tr;
        trip = 1'b0;
        if (s.current_sample < cur_limit_cfg) begin
            oc_count = '0;
        end else begin
            if (oc_count != COUNT_MAX) begin
                oc_count = oc_count + 8'd1;
            end
            // a persistence of zero trips on the first overcurrent sample
            trip = (oc_count >= persist_cfg);
        end
        fan_hs = step_thermal_machine(s.heatsink_sample, hs_thr_cfg, hs_mode, hs_alarm);
        fan_tr = step_thermal_machine(s.transformer_sample, tr_thr_cfg, tr_mode, tr_alarm);
        r.fan_on            = fan_hs | fan_tr;
        r.overcurrent_trip  = trip;
        r.heatsink_mode     = hs_mode;
        r.heatsink_alarm    = hs_alarm;
        r.transformer_mode  = tr_mode;
        r.transformer_alarm = tr_alarm;
        r.shutdown_request  = trip || hs_mode == MODE_SHUTDOWN || tr_mode == MODE_SHUTDOWN;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: pops the pending queue, bursts with random gaps, and runs the
    // predictor on every accepted transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            oc_count   = '0;
            hs_mode    = MODE_NORMAL;
            tr_mode    = MODE_NORMAL;
            hs_alarm   = 1'b0;
            tr_alarm   = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_status_q.push_back(predict_protection_status(i_in_data));
                accepted_total++;
            end
            // payload held until the transfer completes
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    i_in_data  <= sample_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and receiver stall pattern
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_status_q.size() == 0) begin
                    $display("%0t: result with none pending, expected nothing, actual %h",
                             $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    results_checked++;
                    check_field("fan_on", want.fan_on, o_out_data.fan_on);
                    check_field("overcurrent_trip", want.overcurrent_trip,
                                o_out_data.overcurrent_trip);
                    check_field("heatsink_mode", want.heatsink_mode, o_out_data.heatsink_mode);
                    check_field("heatsink_alarm", want.heatsink_alarm,
                                o_out_data.heatsink_alarm);
                    check_field("transformer_mode", want.transformer_mode,
                                o_out_data.transformer_mode);
                    check_field("transformer_alarm", want.transformer_alarm,
                                o_out_data.transformer_alarm);
                    check_field("shutdown_request", want.shutdown_request,
                                o_out_data.shutdown_request);
                end
            end
            if (hold_off_seen != hold_off_req) begin
                hold_off_seen = hold_off_req;
                hold_left     = HOLD_OFF_LEN;
            end
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(20, 80);
            end else begin
                style_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (stall_style)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after too many cycles without any transfer
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d results still pending", $time,
                         expected_status_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // APB write followed by a read-back of the same register. Called at a
    // rising edge; returns once the bus is idle again.
    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_CURRENT_LIMIT || idx == REG_TRIP_PERSISTENCE) ?
               32'h0000_00FF : 32'hFFFF_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // write lands at this edge
        case (idx)
            REG_CURRENT_LIMIT:    cur_limit_cfg = value[7:0];
            REG_TRIP_PERSISTENCE: persist_cfg   = value[7:0];
            REG_HEATSINK_THR:     hs_thr_cfg    = value;
            REG_TRANSFORMER_THR:  tr_thr_cfg    = value;
        endcase
        reg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & mask) !== (value & mask)) begin
            $display("%0t: read-back of register %s, expected %h, actual %h",
                     $time, idx.name(), value & mask, prdata & mask);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [7:0] limit, input logic [7:0] persist,
                                  input t_thresholds hs_thr, input t_thresholds tr_thr);
        write_register(REG_CURRENT_LIMIT, {24'd0, limit});
        write_register(REG_TRIP_PERSISTENCE, {24'd0, persist});
        write_register(REG_HEATSINK_THR, hs_thr);
        write_register(REG_TRANSFORMER_THR, tr_thr);
        settings_used++;
    endtask

    // Sender pause: wait until every pushed set is accepted and every result
    // is back, then let the pipeline settle
    task automatic wait_drained();
        while (accepted_total != pushed_total || expected_status_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic push_sample(input logic [7:0] cur, input logic [7:0] hs,
                               input logic [7:0] tr);
        t_in_item s;
        s.current_sample     = cur;
        s.heatsink_sample    = hs;
        s.transformer_sample = tr;
        sample_q.push_back(s);
        pushed_total++;
    endtask

    function automatic t_thresholds make_thr(input int f_on, input int s_on,
                                             input int f_rel, input int s_rel);
        t_thresholds t;
        t.fan_on       = f_on[7:0];
        t.shut_on      = s_on[7:0];
        t.fan_release  = f_rel[7:0];
        t.shut_release = s_rel[7:0];
        return t;
    endfunction

    // Ordered thresholds: release points at or below their trip points
    function automatic t_thresholds sane_thr();
        int f;
        int s;
        int fr;
        f  = $urandom_range(20, 200);
        s  = $urandom_range(f + 1, 250);
        fr = $urandom_range(0, f);
        return make_thr(f, s, fr, $urandom_range(fr, s));
    endfunction

    // Mostly near one of the four thresholds, so the machines walk through
    // all their transitions; the rest uniform
    function automatic logic [7:0] pick_temperature(input t_thresholds thr);
        int v;
        case ($urandom_range(0, 4))
            0:       v = thr.fan_on;
            1:       v = thr.shut_on;
            2:       v = thr.fan_release;
            3:       v = thr.shut_release;
            default: return 8'($urandom_range(0, 255));
        endcase
        v = v + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Runs of overcurrent samples of random length around the persistence,
    // broken by a sample under the limit
    function automatic logic [7:0] pick_current();
        if ($urandom_range(0, 6) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        if (oc_run_left > 0) begin
            oc_run_left--;
            return 8'($urandom_range(cur_limit_cfg, 255));
        end
        oc_run_left = $urandom_range(0, int'(persist_cfg) + 2);
        if (cur_limit_cfg == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(0, cur_limit_cfg - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int n_items;
        int ph;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: thresholds all ones keep both machines normal,
        // only a full-scale current counts, trip after three in a row
        push_sample(8'd255, 8'd0, 8'd0);
        push_sample(8'd255, 8'd0, 8'd0);
        push_sample(8'd255, 8'd255, 8'd255);
        push_sample(8'd254, 8'd128, 8'd1);
        push_sample(8'd255, 8'd255, 8'd0);
        wait_drained();

        // Zero persistence and ordered thresholds; walk every transition
        // heatsink: fan 50, shut 200, fan release 40, shut release 150
        // transformer: fan 80, shut 180, fan release 60, shut release 120
        apply_settings(8'd100, 8'd0, make_thr(50, 200, 40, 150),
                       make_thr(80, 180, 60, 120));
        push_sample(8'd100, 8'd60, 8'd0);    // hs to fan, instant trip
        push_sample(8'd99, 8'd45, 8'd81);    // hs holds fan, tr to fan, trip clears
        push_sample(8'd0, 8'd30, 8'd61);     // hs fan to normal, tr holds fan
        push_sample(8'd255, 8'd210, 8'd60);  // hs straight to shutdown, tr to normal
        push_sample(8'd100, 8'd160, 8'd255); // hs holds shutdown, tr to shutdown
        push_sample(8'd101, 8'd100, 8'd121); // hs shutdown to fan, alarm sticks
        push_sample(8'd50, 8'd10, 8'd100);   // hs fan to normal, alarm still set
        push_sample(8'd50, 8'd50, 8'd59);    // hs normal at threshold, alarm clears
        push_sample(8'd50, 8'd255, 8'd80);   // hs to shutdown, tr alarm clears
        push_sample(8'd50, 8'd0, 8'd181);    // hs shutdown to normal directly
        push_sample(8'd50, 8'd0, 8'd60);     // tr shutdown to normal
        push_sample(8'd255, 8'd51, 8'd0);    // hs just over fan-on
        wait_drained();

        // Random phases, each under its own settings
        for (ph = 0; ph < 6; ph++) begin
            n_items = 32;
            case (ph)
                0: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(1, 6)),
                                  sane_thr(), sane_thr());
                1: begin
                    // every sample is overcurrent: the counter runs into its
                    // ceiling and the trip comes at the largest persistence
                    apply_settings(8'd0, 8'd255, sane_thr(), sane_thr());
                    n_items = 270;
                end
                2: apply_settings(8'd255, 8'd1, make_thr(0, 0, 0, 0), sane_thr());
                3: apply_settings(8'($urandom_range(0, 255)), 8'd0,
                                  t_thresholds'($urandom()), t_thresholds'($urandom()));
                4: apply_settings(8'd1, 8'd2, THRESHOLDS_RST, t_thresholds'($urandom()));
                default: apply_settings(8'($urandom_range(0, 255)),
                                        8'($urandom_range(1, 8)),
                                        sane_thr(), t_thresholds'($urandom()));
            endcase
            repeat (n_items) begin
                push_sample(pick_current(), pick_temperature(hs_thr_cfg),
                            pick_temperature(tr_thr_cfg));
            end
            // long receiver hold-off while the sender keeps offering, so the
            // pipeline fills and input ready drops
            if (ph == 0) begin
                hold_off_req++;
            end
            wait_drained();
        end

        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        $display("Run covered %0d sample transfers and %0d checked results", accepted_total,
                 results_checked);
        $display("across %0d settings with %0d register writes read back", settings_used + 1,
                 reg_writes);
        if (mismatch_count == 0 && expected_status_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tops_pkg.sv
design/tops_sensor.sv
design/tops_ocp.sv
design/thermal_overcurrent_protection_unit.sv
test/tb.sv
